@@ hdl/h264fu_pkg.sv @@
`timescale 1ns / 1ps

package h264fu_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAGMENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TS_STEP      = 1'b1;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] MAX_FRAGMENT_RST = 16'd1400;
  localparam logic [31:0] TS_STEP_RST      = 32'd3600;

  // FU-A header fields
  localparam logic [7:0] NRI_MASK  = 8'hE0;
  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] FU_S_BIT  = 8'h80;
  localparam logic [7:0] FU_E_BIT  = 8'h40;

  localparam int RES_PER_ITEM = 3;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = 2;
  localparam int Q_CNT_W      = 3;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [31:0] ts;
    logic        run_last;
  } res_t;

endpackage

@@ hdl/h264_fu_a_packetizer.sv @@
`timescale 1ns / 1ps

// Channel | Ports                                         | Dir
// --------+-----------------------------------------------+----
// in      | in_valid/in_ready, in_data_byte, in_nal_length, in_frame_last | in
// out     | out_valid/out_ready, out_byte, out_packet_first, out_packet_last,
//         | out_rtp_timestamp, out_run_last               | out
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data      | in
//
// One input byte per cycle while in_ready. Each byte yields 0 to 3 output items,
// all built in the accept cycle and written to a 4-entry result queue drained at
// one item per cycle while out_ready; input is taken while at most one item is
// queued. FU-A starts add two items. Reset (rst_n low, synchronous) clears
// unit state, timestamp and queue, restores cfg defaults. cfg is always ready.
module h264_fu_a_packetizer #(
  parameter int LENGTH_BITS = h264fu_pkg::LENGTH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  input  logic [LENGTH_BITS-1:0]             in_nal_length,
  input  logic                               in_frame_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               out_packet_first,
  output logic                               out_packet_last,
  output logic [31:0]                        out_rtp_timestamp,
  output logic                               out_run_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [h264fu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [h264fu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  // configuration
  logic [15:0] max_frag_r;
  logic [31:0] ts_step_r;

  // unit state
  logic [LENGTH_BITS-1:0] byte_index_r, byte_index_nxt;
  logic                   long_sc_r, long_sc_nxt;
  logic                   fragmenting_r, fragmenting_nxt;
  logic [7:0]             saved_hdr_r, saved_hdr_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [LENGTH_BITS-1:0] fill_r, fill_nxt;
  logic                   first_frag_r, first_frag_nxt;
  logic [31:0]            time_r, time_nxt;

  // result queue
  h264fu_pkg::res_t q_r [h264fu_pkg::Q_DEPTH];
  logic [h264fu_pkg::Q_PTR_W-1:0] head_r, tail_r;
  logic [h264fu_pkg::Q_CNT_W-1:0] count_r;

  logic in_acc, pop;
  h264fu_pkg::res_t res [h264fu_pkg::RES_PER_ITEM];
  logic [1:0] n_res, n_push;

  logic [15:0]            limit;
  logic [CMP_W-1:0]       limit_ext;
  logic [LENGTH_BITS-1:0] hdr_len, payload, fill_inc, left_dec;
  logic                   endp;
  logic [LENGTH_BITS:0]   bi_inc;
  logic [7:0]             fu_hdr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count_r <= h264fu_pkg::Q_CNT_W'(1));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;

  assign out_byte          = q_r[head_r].data;
  assign out_packet_first  = q_r[head_r].first;
  assign out_packet_last   = q_r[head_r].last;
  assign out_rtp_timestamp = q_r[head_r].ts;
  assign out_run_last      = q_r[head_r].run_last;

  assign limit     = (max_frag_r == '0) ? 16'd1 : max_frag_r;
  assign limit_ext = CMP_W'(limit);
  assign fill_inc  = fill_r + LENGTH_BITS'(1);
  assign left_dec  = left_r - LENGTH_BITS'(1);
  assign endp      = (CMP_W'(fill_inc) >= limit_ext) || (left_dec == '0);
  assign bi_inc    = {1'b0, byte_index_r} + (LENGTH_BITS+1)'(1);

  always_comb begin
    fu_hdr = saved_hdr_r & h264fu_pkg::TYPE_MASK;
    if (first_frag_r) begin
      fu_hdr = fu_hdr | h264fu_pkg::FU_S_BIT;
    end else if (CMP_W'(left_r) <= limit_ext) begin
      fu_hdr = fu_hdr | h264fu_pkg::FU_E_BIT;
    end
  end

  always_comb begin
    byte_index_nxt  = byte_index_r;
    long_sc_nxt     = long_sc_r;
    fragmenting_nxt = fragmenting_r;
    saved_hdr_nxt   = saved_hdr_r;
    left_nxt        = left_r;
    fill_nxt        = fill_r;
    first_frag_nxt  = first_frag_r;
    time_nxt        = time_r;
    n_res           = 2'd0;
    payload         = '0;
    for (int k = 0; k < h264fu_pkg::RES_PER_ITEM; k++) begin
      res[k] = '{data: in_data_byte, first: 1'b0, last: 1'b0, ts: time_r, run_last: 1'b0};
    end

    // byte 2 of a unit tells a 3-byte start code (bit 0 set) from a 4-byte one
    if (byte_index_r == LENGTH_BITS'(2)) begin
      long_sc_nxt = ~in_data_byte[0];
    end
    hdr_len = long_sc_nxt ? LENGTH_BITS'(4) : LENGTH_BITS'(3);

    if (byte_index_r == hdr_len) begin
      payload  = (in_nal_length > hdr_len) ? (in_nal_length - hdr_len) : '0;
      fill_nxt = '0;
      if (CMP_W'(payload) > limit_ext) begin
        fragmenting_nxt = 1'b1;
        saved_hdr_nxt   = in_data_byte;
        left_nxt        = payload - LENGTH_BITS'(1);
        first_frag_nxt  = 1'b1;
      end else if (payload != '0) begin
        fragmenting_nxt = 1'b0;
        res[0].first    = 1'b1;
        res[0].last     = (payload == LENGTH_BITS'(1));
        n_res           = 2'd1;
        left_nxt        = payload - LENGTH_BITS'(1);
      end else begin
        fragmenting_nxt = 1'b0;
        left_nxt        = '0;
      end
    end else if ((byte_index_r > hdr_len) && (left_r != '0)) begin
      left_nxt = left_dec;
      if (fragmenting_r) begin
        fill_nxt = endp ? '0 : fill_inc;
        if (endp) begin
          first_frag_nxt = 1'b0;
        end
        if (fill_r == '0) begin
          res[0].data  = (saved_hdr_r & h264fu_pkg::NRI_MASK) | h264fu_pkg::FU_A_TYPE;
          res[0].first = 1'b1;
          res[1].data  = fu_hdr;
          res[2].last  = endp;
          n_res        = 2'd3;
        end else begin
          res[0].last = endp;
          n_res       = 2'd1;
        end
      end else begin
        res[0].last = (left_r == LENGTH_BITS'(1));
        n_res       = 2'd1;
      end
    end

    for (int k = 0; k < h264fu_pkg::RES_PER_ITEM; k++) begin
      res[k].run_last = (n_res == 2'(k + 1));
    end

    if (bi_inc >= {1'b0, in_nal_length}) begin
      byte_index_nxt  = '0;
      long_sc_nxt     = 1'b0;
      fragmenting_nxt = 1'b0;
      saved_hdr_nxt   = '0;
      left_nxt        = '0;
      fill_nxt        = '0;
      first_frag_nxt  = 1'b1;
      if (in_frame_last) begin
        time_nxt = time_r + ts_step_r;
      end
    end else begin
      byte_index_nxt = bi_inc[LENGTH_BITS-1:0];
    end
  end

  assign n_push = in_acc ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frag_r <= h264fu_pkg::MAX_FRAGMENT_RST;
      ts_step_r  <= h264fu_pkg::TS_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        h264fu_pkg::REG_MAX_FRAGMENT: max_frag_r <= cfg_data[15:0];
        h264fu_pkg::REG_TS_STEP:      ts_step_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r  <= '0;
      long_sc_r     <= 1'b0;
      fragmenting_r <= 1'b0;
      saved_hdr_r   <= '0;
      left_r        <= '0;
      fill_r        <= '0;
      first_frag_r  <= 1'b1;
      time_r        <= '0;
    end else if (in_acc) begin
      byte_index_r  <= byte_index_nxt;
      long_sc_r     <= long_sc_nxt;
      fragmenting_r <= fragmenting_nxt;
      saved_hdr_r   <= saved_hdr_nxt;
      left_r        <= left_nxt;
      fill_r        <= fill_nxt;
      first_frag_r  <= first_frag_nxt;
      time_r        <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_r + h264fu_pkg::Q_PTR_W'(pop);
      tail_r  <= tail_r + h264fu_pkg::Q_PTR_W'(n_push);
      count_r <= count_r + h264fu_pkg::Q_CNT_W'(n_push) - h264fu_pkg::Q_CNT_W'(pop);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < h264fu_pkg::RES_PER_ITEM; k++) begin
      if (2'(k) < n_push) begin
        q_r[tail_r + h264fu_pkg::Q_PTR_W'(k)] <= res[k];
      end
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= h264fu_pkg::Q_CNT_W'(h264fu_pkg::Q_DEPTH))
    else $error("result queue overflow");

  a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fragmenting_r |-> fill_r == '0)
    else $error("fragment fill nonzero outside fragmentation");

  a_first_frag: assert property (@(posedge clk) disable iff (!rst_n)
    !first_frag_r |-> fragmenting_r)
    else $error("first fragment flag cleared outside fragmentation");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && n_push == 2'd0) |=> count_r == $past(count_r) - h264fu_pkg::Q_CNT_W'(1))
    else $error("queue count did not follow a pop");

endmodule
